@@ rtl/sidta_pkg.sv @@
// Shared types and constants for the signed integer to decimal ASCII unit.
package sidta_pkg;

    localparam int VALUE_W    = 32;
    localparam int CHAR_W     = 8;
    localparam int NUM_BCD    = 10;
    localparam int BCD_W      = NUM_BCD * 4;
    localparam int MAX_DIGITS = 10;
    localparam int CAP_LO     = (MAX_DIGITS < 1) ? 1 : MAX_DIGITS;
    localparam int DIGIT_CAP  = (CAP_LO > NUM_BCD) ? NUM_BCD : CAP_LO;
    localparam int CNT_W      = $clog2(NUM_BCD + 1);
    localparam int IDX_W      = $clog2(NUM_BCD);
    localparam int SHIFT_W    = $clog2(VALUE_W);
    localparam int QDEPTH     = 2;
    localparam int QPTR_W     = $clog2(QDEPTH);
    localparam int QCNT_W     = $clog2(QDEPTH + 1);

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'd57;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;

    typedef struct packed {
        logic               neg;
        logic               zero;
        logic [VALUE_W-1:0] mag;
    } entry_t;

endpackage

@@ rtl/signed_int_to_decimal_ascii_unit.sv @@
// Top level of the signed integer to decimal ASCII unit.
// An item is taken when start is high and busy is low; a two-entry queue
// holds taken items, so busy rises only when both entries wait. Each item
// is dequeued, converted to BCD by shift-add-3 over all 32 magnitude bits
// (skipped for zero) and sized to its text. Characters come out on
// consecutive cycles, one per strobe, most significant first, with
// last_char on the final one; the receiver cannot stall them.
module signed_int_to_decimal_ascii_unit
    import sidta_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic signed [VALUE_W-1:0] value,
    output logic                      strobe,
    output logic [CHAR_W-1:0]         char_code,
    output logic                      last_char
);

    logic   push;
    logic   pop;
    logic   empty;
    logic   full;
    entry_t push_entry;
    entry_t head;

    sidta_front u_front
    (
        .start (start),
        .value (value),
        .full  (full),
        .busy  (busy),
        .push  (push),
        .entry (push_entry)
    );

    sidta_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .empty      (empty),
        .full       (full)
    );

    sidta_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .empty     (empty),
        .head      (head),
        .pop       (pop),
        .strobe    (strobe),
        .char_code (char_code),
        .last_char (last_char)
    );

    a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> (char_code == CHAR_MINUS ||
                    (char_code >= CHAR_ZERO && char_code <= CHAR_NINE)))
        else $error("character out of range");

    a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && char_code == CHAR_MINUS) |-> !last_char)
        else $error("minus sign flagged as last");

    a_text_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && !last_char) |=> strobe)
        else $error("gap inside a number's text");

endmodule

@@ rtl/sidta_front.sv @@
// Front end: takes an item, splits it into sign and magnitude, flags zero.
module sidta_front
    import sidta_pkg::*;
(
    input  logic                      start,
    input  logic signed [VALUE_W-1:0] value,
    input  logic                      full,
    output logic                      busy,
    output logic                      push,
    output entry_t                    entry
);

    logic neg;

    assign neg        = value[VALUE_W-1];
    assign busy       = full;
    assign push       = start && !full;
    assign entry.neg  = neg;
    assign entry.mag  = neg ? (VALUE_W'(0) - VALUE_W'(value)) : VALUE_W'(value);
    assign entry.zero = (value == '0);

endmodule

@@ rtl/sidta_queue.sv @@
// Short queue of classified items between front end and converter.
module sidta_queue
    import sidta_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  entry_t push_entry,
    input  logic   pop,
    output entry_t head,
    output logic   empty,
    output logic   full
);

    entry_t             q_reg [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg, count_next;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == QCNT_W'(QDEPTH));
    assign head  = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

@@ rtl/sidta_back.sv @@
// Back end: shift-add-3 binary to BCD, then character emission.
module sidta_back
    import sidta_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              empty,
    input  entry_t            head,
    output logic              pop,
    output logic              strobe,
    output logic [CHAR_W-1:0] char_code,
    output logic              last_char
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CONV  = 3'd1;
    localparam logic [2:0] ST_SIZE  = 3'd2;
    localparam logic [2:0] ST_SIGN  = 3'd3;
    localparam logic [2:0] ST_DIGIT = 3'd4;

    logic [2:0]         state_reg, state_next;
    logic [SHIFT_W-1:0] shift_reg, shift_next;
    logic [VALUE_W-1:0] mag_reg, mag_next;
    logic [BCD_W-1:0]   bcd_reg, bcd_next;
    logic               neg_reg, neg_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic               strobe_reg, strobe_next;
    logic [CHAR_W-1:0]  char_reg, char_next;
    logic               last_reg, last_next;
    logic [BCD_W-1:0]   bcd_adj;
    logic [CNT_W-1:0]   ndig;
    logic [CNT_W-1:0]   nkeep;
    logic [3:0]         cur_digit;

    assign strobe    = strobe_reg;
    assign char_code = char_reg;
    assign last_char = last_reg;
    assign pop       = (state_reg == ST_IDLE) && !empty;
    assign cur_digit = bcd_reg[idx_reg * 4 +: 4];

    always_comb
    begin
        for (int i = 0; i < NUM_BCD; i++)
        begin
            bcd_adj[i*4 +: 4] = (bcd_reg[i*4 +: 4] >= 4'd5) ?
                                bcd_reg[i*4 +: 4] + 4'd3 : bcd_reg[i*4 +: 4];
        end
    end

    always_comb
    begin
        ndig = CNT_W'(1);
        for (int i = 0; i < NUM_BCD; i++)
        begin
            if (bcd_reg[i*4 +: 4] != 4'd0)
            begin
                ndig = CNT_W'(i + 1);
            end
        end
        nkeep = (ndig > CNT_W'(DIGIT_CAP)) ? CNT_W'(DIGIT_CAP) : ndig;
    end

    always_comb
    begin
        state_next  = state_reg;
        shift_next  = shift_reg;
        mag_next    = mag_reg;
        bcd_next    = bcd_reg;
        neg_next    = neg_reg;
        idx_next    = idx_reg;
        strobe_next = 1'b0;
        char_next   = char_reg;
        last_next   = last_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!empty)
                begin
                    neg_next   = head.neg;
                    mag_next   = head.mag;
                    bcd_next   = '0;
                    shift_next = '0;
                    state_next = head.zero ? ST_SIZE : ST_CONV;
                end
            end
            ST_CONV:
            begin
                bcd_next   = {bcd_adj[BCD_W-2:0], mag_reg[VALUE_W-1]};
                mag_next   = {mag_reg[VALUE_W-2:0], 1'b0};
                shift_next = shift_reg + 1'b1;
                if (shift_reg == SHIFT_W'(VALUE_W - 1))
                begin
                    state_next = ST_SIZE;
                end
            end
            ST_SIZE:
            begin
                idx_next   = IDX_W'(nkeep - 1'b1);
                state_next = neg_reg ? ST_SIGN : ST_DIGIT;
            end
            ST_SIGN:
            begin
                strobe_next = 1'b1;
                char_next   = CHAR_MINUS;
                last_next   = 1'b0;
                state_next  = ST_DIGIT;
            end
            ST_DIGIT:
            begin
                strobe_next = 1'b1;
                char_next   = CHAR_ZERO + CHAR_W'(cur_digit);
                last_next   = (idx_reg == '0);
                idx_next    = idx_reg - 1'b1;
                if (idx_reg == '0)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        mag_reg   <= mag_next;
        bcd_reg   <= bcd_next;
        neg_reg   <= neg_next;
        idx_reg   <= idx_next;
        char_reg  <= char_next;
        last_reg  <= last_next;
    end

endmodule
